// ----- hdl/bptg_pkg.sv -----
// Shared constants, types and codes for the bilinear position tap generator.
package bptg_pkg;

    localparam int MAX_GRID_SIDE    = 1024;
    localparam int MAX_TABLE_SIDE   = 256;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int MAX_MERGE        = 8;

    localparam int CFG_GRID_W  = $clog2(MAX_GRID_SIDE) + 1;
    localparam int GRID_W      = $clog2(MAX_GRID_SIDE);
    localparam int MERGE_W     = $clog2(MAX_MERGE) + 1;
    localparam int INNER_W     = $clog2(MAX_MERGE);
    localparam int TABLE_W     = $clog2(MAX_TABLE_SIDE) + 1;
    localparam int TAP_W       = $clog2(MAX_TABLE_SIDE);
    localparam int CFG_DATA_W  = (CFG_GRID_W > TABLE_W) ? CFG_GRID_W : TABLE_W;
    localparam int CFG_INDEX_W = 3;

    localparam int INDEX_W   = 16;
    localparam int FRAC_W    = WEIGHT_FRAC_BITS;
    localparam int WEIGHT_W  = WEIGHT_FRAC_BITS + 1;
    localparam int IDX_SUM_W = TAP_W + TABLE_W;
    localparam int NUM_W     = GRID_W + TAP_W;
    localparam int DIV_W     = NUM_W + FRAC_W;
    localparam int DEN_W     = GRID_W;
    localparam int STEP_W    = $clog2(DIV_W + 1);
    localparam int SCALE_W   = GRID_W + MERGE_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_FRAMES = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_MERGE_SIZE  = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIDE  = CFG_INDEX_W'(4);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_DIV_H,
        ST_DIV_W,
        ST_SCALE,
        ST_COORD,
        ST_NUM,
        ST_DIV_R,
        ST_DIV_C,
        ST_PROD,
        ST_OUT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DEN_W-1:0] rem;
    } div_rsp_t;

endpackage

// ----- hdl/bilinear_position_tap_generator.sv -----
// Top level: patch walker and tap sequencer around the shared divider.
//
//   Channel  Direction  Handshake              Word
//   s_       in         s_valid / s_ready      s_restart
//   m_       out        m_valid / m_ready      tap indices, weights, patch, flags
//   cfg_     in         cfg_wr_en (no wait)    cfg_index, cfg_wdata
//
// Each word runs two 11-step divisibility checks and two 34-step coordinate
// divisions on the one radix-2 divider, plus sequencing. A bad configuration
// ends after the range check or the first failing divisibility check.
// Reset is synchronous and active low; it sets the configuration registers to
// one and clears the walk counters and the output valid flag. A finished word
// waits in the output register while the next input word is taken; the
// sequencer stalls only when it must write a new result before the previous
// one has been taken.
module bilinear_position_tap_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_restart,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bptg_pkg::INDEX_W-1:0]        m_tap_index_00,
    output logic [bptg_pkg::INDEX_W-1:0]        m_tap_index_01,
    output logic [bptg_pkg::INDEX_W-1:0]        m_tap_index_10,
    output logic [bptg_pkg::INDEX_W-1:0]        m_tap_index_11,
    output logic [bptg_pkg::WEIGHT_W-1:0]       m_weight_00,
    output logic [bptg_pkg::WEIGHT_W-1:0]       m_weight_01,
    output logic [bptg_pkg::WEIGHT_W-1:0]       m_weight_10,
    output logic [bptg_pkg::WEIGHT_W-1:0]       m_weight_11,
    output logic [bptg_pkg::GRID_W-1:0]         m_patch_row,
    output logic [bptg_pkg::GRID_W-1:0]         m_patch_column,
    output logic                                m_last_patch,
    output logic                                m_grid_error,
    input  logic                                cfg_wr_en,
    input  logic [bptg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bptg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CG = bptg_pkg::CFG_GRID_W;
    localparam int GW = bptg_pkg::GRID_W;
    localparam int MW = bptg_pkg::MERGE_W;
    localparam int IW = bptg_pkg::INNER_W;
    localparam int TW = bptg_pkg::TABLE_W;
    localparam int PW = bptg_pkg::TAP_W;
    localparam int SW = bptg_pkg::SCALE_W;
    localparam int WW = bptg_pkg::WEIGHT_W;
    localparam int XW = bptg_pkg::INDEX_W;
    localparam int FW = bptg_pkg::FRAC_W;
    localparam int NW = bptg_pkg::NUM_W;
    localparam int DW = bptg_pkg::DIV_W;

    bptg_pkg::state_t   state_reg, state_next;
    bptg_pkg::div_req_t div_req;
    bptg_pkg::div_rsp_t div_rsp;

    logic [CG-1:0] grid_height_reg, grid_height_next;
    logic [CG-1:0] grid_width_reg, grid_width_next;
    logic [CG-1:0] grid_frames_reg, grid_frames_next;
    logic [MW-1:0] merge_size_reg, merge_size_next;
    logic [TW-1:0] table_side_reg, table_side_next;

    logic [GW-1:0] frame_count_reg, frame_count_next;
    logic [GW-1:0] block_row_count_reg, block_row_count_next;
    logic [GW-1:0] block_column_count_reg, block_column_count_next;
    logic [IW-1:0] inner_row_count_reg, inner_row_count_next;
    logic [IW-1:0] inner_column_count_reg, inner_column_count_next;

    logic          restart_reg, restart_next;
    logic [SW-1:0] brm_reg, brm_next;
    logic [SW-1:0] bcm_reg, bcm_next;
    logic [GW-1:0] row_reg, row_next;
    logic [GW-1:0] col_reg, col_next;
    logic          last_reg, last_next;
    logic [DW-1:0] quo_r_reg, quo_r_next;
    logic [PW-1:0] rt_reg [2];
    logic [PW-1:0] rt_next [2];
    logic [PW-1:0] ct_reg [2];
    logic [PW-1:0] ct_next [2];
    logic [WW-1:0] rw_reg [2];
    logic [WW-1:0] rw_next [2];
    logic [WW-1:0] cw_reg [2];
    logic [WW-1:0] cw_next [2];
    logic [1:0]    k_reg, k_next;
    logic [XW-1:0] idx_reg [4];
    logic [XW-1:0] idx_next [4];
    logic [WW-1:0] w_reg [4];
    logic [WW-1:0] w_next [4];

    logic          m_valid_reg, m_valid_next;
    logic [XW-1:0] m_idx_reg [4];
    logic [XW-1:0] m_idx_next [4];
    logic [WW-1:0] m_w_reg [4];
    logic [WW-1:0] m_w_next [4];
    logic [GW-1:0] m_row_reg, m_row_next;
    logic [GW-1:0] m_col_reg, m_col_next;
    logic          m_last_reg, m_last_next;
    logic          m_error_reg, m_error_next;

    logic                range_ok;
    logic                out_free;
    logic                stale;
    logic [GW-1:0]       f_eff, brc_eff, bcc_eff;
    logic [IW-1:0]       irc_eff, icc_eff;
    logic [SW-1:0]       brm_eff, bcm_eff, row_full, col_full;
    logic                ic_wrap, ir_wrap, bc_wrap, br_wrap, f_wrap;
    logic                last_now;
    logic [bptg_pkg::DEN_W-1:0] den_h, den_w;
    logic [PW-1:0]       side_m1;
    logic [NW-1:0]       num_r, num_c;
    logic [IDX_SUM_W_L-1:0] idx_sum;
    logic [2*WW-1:0]     w_prod;

    localparam int IDX_SUM_W_L = bptg_pkg::IDX_SUM_W;

    bptg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Clamp a floor value or its successor to the last table entry.
    function automatic logic [PW-1:0] clamp_tap(input logic [NW:0] v,
                                                input logic [PW-1:0] top);
        clamp_tap = (v > (NW+1)'(top)) ? top : v[PW-1:0];
    endfunction

    assign range_ok = (grid_height_reg != '0) && (grid_height_reg <= CG'(bptg_pkg::MAX_GRID_SIDE))
                   && (grid_width_reg != '0) && (grid_width_reg <= CG'(bptg_pkg::MAX_GRID_SIDE))
                   && (grid_frames_reg != '0) && (grid_frames_reg <= CG'(bptg_pkg::MAX_GRID_SIDE))
                   && (merge_size_reg != '0) && (merge_size_reg <= MW'(bptg_pkg::MAX_MERGE))
                   && (table_side_reg != '0) && (table_side_reg <= TW'(bptg_pkg::MAX_TABLE_SIDE));

    assign out_free = !m_valid_reg || m_ready;

    assign den_h = (grid_height_reg > CG'(1)) ? bptg_pkg::DEN_W'(grid_height_reg - CG'(1))
                                              : bptg_pkg::DEN_W'(1);
    assign den_w = (grid_width_reg > CG'(1)) ? bptg_pkg::DEN_W'(grid_width_reg - CG'(1))
                                             : bptg_pkg::DEN_W'(1);
    assign side_m1 = PW'(table_side_reg - TW'(1));
    assign num_r   = NW'(row_reg * side_m1);
    assign num_c   = NW'(col_reg * side_m1);

    // Counters left outside the grid by a configuration change count as a
    // restart. Block counts are compared as multiples of the merge size.
    assign stale = restart_reg
                || ({1'b0, frame_count_reg} >= grid_frames_reg)
                || (brm_reg >= SW'(grid_height_reg))
                || (bcm_reg >= SW'(grid_width_reg))
                || ({1'b0, inner_row_count_reg} >= merge_size_reg)
                || ({1'b0, inner_column_count_reg} >= merge_size_reg);

    assign f_eff   = stale ? '0 : frame_count_reg;
    assign brc_eff = stale ? '0 : block_row_count_reg;
    assign bcc_eff = stale ? '0 : block_column_count_reg;
    assign irc_eff = stale ? '0 : inner_row_count_reg;
    assign icc_eff = stale ? '0 : inner_column_count_reg;
    assign brm_eff = stale ? '0 : brm_reg;
    assign bcm_eff = stale ? '0 : bcm_reg;
    assign row_full = brm_eff + SW'(irc_eff);
    assign col_full = bcm_eff + SW'(icc_eff);

    assign ic_wrap = (MW'(icc_eff) + MW'(1)) >= merge_size_reg;
    assign ir_wrap = (MW'(irc_eff) + MW'(1)) >= merge_size_reg;
    assign bc_wrap = (bcm_eff + SW'(merge_size_reg)) >= SW'(grid_width_reg);
    assign br_wrap = (brm_eff + SW'(merge_size_reg)) >= SW'(grid_height_reg);
    assign f_wrap  = (CG'(f_eff) + CG'(1)) >= grid_frames_reg;

    assign last_now = (CG'(f_eff) == grid_frames_reg - CG'(1))
                   && (brm_eff == SW'(grid_height_reg - CG'(merge_size_reg)))
                   && (bcm_eff == SW'(grid_width_reg - CG'(merge_size_reg)))
                   && (MW'(irc_eff) == merge_size_reg - MW'(1))
                   && (MW'(icc_eff) == merge_size_reg - MW'(1));

    assign idx_sum = IDX_SUM_W_L'(rt_reg[k_reg[1]] * table_side_reg)
                   + IDX_SUM_W_L'(ct_reg[k_reg[0]]);
    assign w_prod  = rw_reg[k_reg[1]] * cw_reg[k_reg[0]];

    always_comb begin
        state_next              = state_reg;
        grid_height_next        = grid_height_reg;
        grid_width_next         = grid_width_reg;
        grid_frames_next        = grid_frames_reg;
        merge_size_next         = merge_size_reg;
        table_side_next         = table_side_reg;
        frame_count_next        = frame_count_reg;
        block_row_count_next    = block_row_count_reg;
        block_column_count_next = block_column_count_reg;
        inner_row_count_next    = inner_row_count_reg;
        inner_column_count_next = inner_column_count_reg;
        restart_next            = restart_reg;
        brm_next                = brm_reg;
        bcm_next                = bcm_reg;
        row_next                = row_reg;
        col_next                = col_reg;
        last_next               = last_reg;
        quo_r_next              = quo_r_reg;
        rt_next                 = rt_reg;
        ct_next                 = ct_reg;
        rw_next                 = rw_reg;
        cw_next                 = cw_reg;
        k_next                  = k_reg;
        idx_next                = idx_reg;
        w_next                  = w_reg;
        m_valid_next            = m_valid_reg && !m_ready;
        m_idx_next              = m_idx_reg;
        m_w_next                = m_w_reg;
        m_row_next              = m_row_reg;
        m_col_next              = m_col_reg;
        m_last_next             = m_last_reg;
        m_error_next            = m_error_reg;
        div_req                 = '0;

        if (cfg_wr_en) begin
            case (cfg_index)
                bptg_pkg::CFG_GRID_HEIGHT: grid_height_next = CG'(cfg_wdata);
                bptg_pkg::CFG_GRID_WIDTH:  grid_width_next  = CG'(cfg_wdata);
                bptg_pkg::CFG_GRID_FRAMES: grid_frames_next = CG'(cfg_wdata);
                bptg_pkg::CFG_MERGE_SIZE:  merge_size_next  = MW'(cfg_wdata);
                bptg_pkg::CFG_TABLE_SIDE:  table_side_next  = TW'(cfg_wdata);
                default: ;
            endcase
        end

        case (state_reg)
            bptg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    restart_next = s_restart;
                    state_next   = bptg_pkg::ST_RANGE;
                end
            end
            bptg_pkg::ST_RANGE: begin
                if (range_ok) begin
                    div_req.start = 1'b1;
                    div_req.steps = bptg_pkg::STEP_W'(CG);
                    div_req.num   = {grid_height_reg, {(DW-CG){1'b0}}};
                    div_req.den   = bptg_pkg::DEN_W'(merge_size_reg);
                    state_next    = bptg_pkg::ST_DIV_H;
                end else begin
                    state_next = bptg_pkg::ST_ERR;
                end
            end
            bptg_pkg::ST_DIV_H: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem != '0) begin
                        state_next = bptg_pkg::ST_ERR;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.steps = bptg_pkg::STEP_W'(CG);
                        div_req.num   = {grid_width_reg, {(DW-CG){1'b0}}};
                        div_req.den   = bptg_pkg::DEN_W'(merge_size_reg);
                        state_next    = bptg_pkg::ST_DIV_W;
                    end
                end
            end
            bptg_pkg::ST_DIV_W: begin
                if (div_rsp.done) begin
                    state_next = (div_rsp.rem != '0) ? bptg_pkg::ST_ERR : bptg_pkg::ST_SCALE;
                end
            end
            bptg_pkg::ST_SCALE: begin
                brm_next   = SW'(block_row_count_reg * merge_size_reg);
                bcm_next   = SW'(block_column_count_reg * merge_size_reg);
                state_next = bptg_pkg::ST_COORD;
            end
            bptg_pkg::ST_COORD: begin
                row_next  = GW'(row_full);
                col_next  = GW'(col_full);
                last_next = last_now;
                // Advance in merge-block order: inner column first, frame last.
                frame_count_next        = f_eff;
                block_row_count_next    = brc_eff;
                block_column_count_next = bcc_eff;
                inner_row_count_next    = irc_eff;
                if (!ic_wrap) begin
                    inner_column_count_next = icc_eff + IW'(1);
                end else begin
                    inner_column_count_next = '0;
                    if (!ir_wrap) begin
                        inner_row_count_next = irc_eff + IW'(1);
                    end else begin
                        inner_row_count_next = '0;
                        if (!bc_wrap) begin
                            block_column_count_next = bcc_eff + GW'(1);
                        end else begin
                            block_column_count_next = '0;
                            if (!br_wrap) begin
                                block_row_count_next = brc_eff + GW'(1);
                            end else begin
                                block_row_count_next = '0;
                                frame_count_next = f_wrap ? '0 : f_eff + GW'(1);
                            end
                        end
                    end
                end
                state_next = bptg_pkg::ST_NUM;
            end
            bptg_pkg::ST_NUM: begin
                // Dividing the numerator scaled by the weight unit yields the
                // floor and the fraction in one quotient.
                div_req.start = 1'b1;
                div_req.steps = bptg_pkg::STEP_W'(DW);
                div_req.num   = {num_r, {FW{1'b0}}};
                div_req.den   = den_h;
                state_next    = bptg_pkg::ST_DIV_R;
            end
            bptg_pkg::ST_DIV_R: begin
                if (div_rsp.done) begin
                    quo_r_next    = div_rsp.quo;
                    div_req.start = 1'b1;
                    div_req.steps = bptg_pkg::STEP_W'(DW);
                    div_req.num   = {num_c, {FW{1'b0}}};
                    div_req.den   = den_w;
                    state_next    = bptg_pkg::ST_DIV_C;
                end
            end
            bptg_pkg::ST_DIV_C: begin
                if (div_rsp.done) begin
                    rt_next[0] = clamp_tap({1'b0, quo_r_reg[DW-1:FW]}, side_m1);
                    rt_next[1] = clamp_tap({1'b0, quo_r_reg[DW-1:FW]} + (NW+1)'(1), side_m1);
                    ct_next[0] = clamp_tap({1'b0, div_rsp.quo[DW-1:FW]}, side_m1);
                    ct_next[1] = clamp_tap({1'b0, div_rsp.quo[DW-1:FW]} + (NW+1)'(1), side_m1);
                    rw_next[0] = bptg_pkg::WEIGHT_ONE - WW'(quo_r_reg[FW-1:0]);
                    rw_next[1] = WW'(quo_r_reg[FW-1:0]);
                    cw_next[0] = bptg_pkg::WEIGHT_ONE - WW'(div_rsp.quo[FW-1:0]);
                    cw_next[1] = WW'(div_rsp.quo[FW-1:0]);
                    k_next     = '0;
                    state_next = bptg_pkg::ST_PROD;
                end
            end
            bptg_pkg::ST_PROD: begin
                idx_next[k_reg] = XW'(idx_sum);
                w_next[k_reg]   = w_prod[FW +: WW];
                k_next          = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    state_next = bptg_pkg::ST_OUT;
                end
            end
            bptg_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = idx_reg;
                    m_w_next     = w_reg;
                    m_row_next   = row_reg;
                    m_col_next   = col_reg;
                    m_last_next  = last_reg;
                    m_error_next = 1'b0;
                    state_next   = bptg_pkg::ST_IDLE;
                end
            end
            bptg_pkg::ST_ERR: begin
                frame_count_next        = '0;
                block_row_count_next    = '0;
                block_column_count_next = '0;
                inner_row_count_next    = '0;
                inner_column_count_next = '0;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = '{default: '0};
                    m_w_next     = '{default: '0};
                    m_row_next   = '0;
                    m_col_next   = '0;
                    m_last_next  = 1'b0;
                    m_error_next = 1'b1;
                    state_next   = bptg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bptg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg              <= bptg_pkg::ST_IDLE;
            grid_height_reg        <= CG'(1);
            grid_width_reg         <= CG'(1);
            grid_frames_reg        <= CG'(1);
            merge_size_reg         <= MW'(1);
            table_side_reg         <= TW'(1);
            frame_count_reg        <= '0;
            block_row_count_reg    <= '0;
            block_column_count_reg <= '0;
            inner_row_count_reg    <= '0;
            inner_column_count_reg <= '0;
            m_valid_reg            <= 1'b0;
        end else begin
            state_reg              <= state_next;
            grid_height_reg        <= grid_height_next;
            grid_width_reg         <= grid_width_next;
            grid_frames_reg        <= grid_frames_next;
            merge_size_reg         <= merge_size_next;
            table_side_reg         <= table_side_next;
            frame_count_reg        <= frame_count_next;
            block_row_count_reg    <= block_row_count_next;
            block_column_count_reg <= block_column_count_next;
            inner_row_count_reg    <= inner_row_count_next;
            inner_column_count_reg <= inner_column_count_next;
            m_valid_reg            <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        restart_reg <= restart_next;
        brm_reg     <= brm_next;
        bcm_reg     <= bcm_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        last_reg    <= last_next;
        quo_r_reg   <= quo_r_next;
        rt_reg      <= rt_next;
        ct_reg      <= ct_next;
        rw_reg      <= rw_next;
        cw_reg      <= cw_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        w_reg       <= w_next;
        m_idx_reg   <= m_idx_next;
        m_w_reg     <= m_w_next;
        m_row_reg   <= m_row_next;
        m_col_reg   <= m_col_next;
        m_last_reg  <= m_last_next;
        m_error_reg <= m_error_next;
    end

    assign s_ready        = (state_reg == bptg_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_tap_index_00 = m_idx_reg[0];
    assign m_tap_index_01 = m_idx_reg[1];
    assign m_tap_index_10 = m_idx_reg[2];
    assign m_tap_index_11 = m_idx_reg[3];
    assign m_weight_00    = m_w_reg[0];
    assign m_weight_01    = m_w_reg[1];
    assign m_weight_10    = m_w_reg[2];
    assign m_weight_11    = m_w_reg[3];
    assign m_patch_row    = m_row_reg;
    assign m_patch_column = m_col_reg;
    assign m_last_patch   = m_last_reg;
    assign m_grid_error   = m_error_reg;

endmodule

// ----- hdl/bptg_div.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle.
module bptg_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  bptg_pkg::div_req_t req,
    output bptg_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [bptg_pkg::STEP_W-1:0]   cnt_reg;
    logic [bptg_pkg::STEP_W-1:0]   steps_reg;
    logic [bptg_pkg::DEN_W-1:0]    den_reg;
    logic [bptg_pkg::DEN_W-1:0]    rem_reg;
    logic [bptg_pkg::DEN_W-1:0]    rem_next;
    logic [bptg_pkg::DIV_W-1:0]    quo_reg;
    logic [bptg_pkg::DEN_W:0]      shifted;
    logic                          ge;

    // The numerator is shifted out of the top of the quotient register while
    // quotient bits enter at the bottom.
    assign shifted  = {rem_reg, quo_reg[bptg_pkg::DIV_W-1]};
    assign ge       = shifted >= {1'b0, den_reg};
    assign rem_next = ge ? bptg_pkg::DEN_W'(shifted - {1'b0, den_reg})
                         : bptg_pkg::DEN_W'(shifted);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + bptg_pkg::STEP_W'(1);
                if (cnt_reg == steps_reg - bptg_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            steps_reg <= req.steps;
            den_reg   <= req.den;
            rem_reg   <= '0;
            quo_reg   <= req.num;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[bptg_pkg::DIV_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hdl/bptg_check.sv -----
// Port-level checker for the bilinear position tap generator, with its bind.
module bptg_check (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [bptg_pkg::INDEX_W-1:0]       m_tap_index_00,
    input logic [bptg_pkg::INDEX_W-1:0]       m_tap_index_01,
    input logic [bptg_pkg::INDEX_W-1:0]       m_tap_index_10,
    input logic [bptg_pkg::INDEX_W-1:0]       m_tap_index_11,
    input logic [bptg_pkg::WEIGHT_W-1:0]      m_weight_00,
    input logic [bptg_pkg::WEIGHT_W-1:0]      m_weight_01,
    input logic [bptg_pkg::WEIGHT_W-1:0]      m_weight_10,
    input logic [bptg_pkg::WEIGHT_W-1:0]      m_weight_11,
    input logic                               m_last_patch,
    input logic                               m_grid_error
);

    localparam int SUM_W = bptg_pkg::WEIGHT_W + 2;

    logic [SUM_W-1:0] weight_sum;

    assign weight_sum = SUM_W'(m_weight_00) + SUM_W'(m_weight_01)
                      + SUM_W'(m_weight_10) + SUM_W'(m_weight_11);

    // A result word that is not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word withdrawn before it was taken");

    // Each input word is worked on alone, so the port closes after a transfer.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again while a word is in progress");

    // An error word carries no taps, weights or end-of-walk mark.
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_grid_error |-> (weight_sum == '0) && !m_last_patch
            && (m_tap_index_00 == '0) && (m_tap_index_01 == '0)
            && (m_tap_index_10 == '0) && (m_tap_index_11 == '0))
        else $error("error word carries non-zero fields");

    // The four truncated weights sum to one unit, short by at most three.
    a_weight_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_grid_error |->
            (weight_sum <= SUM_W'(bptg_pkg::WEIGHT_ONE))
            && (weight_sum + SUM_W'(3) >= SUM_W'(bptg_pkg::WEIGHT_ONE)))
        else $error("bilinear weights do not sum to one");

endmodule

bind bilinear_position_tap_generator bptg_check u_bptg_check (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_tap_index_00 (m_tap_index_00),
    .m_tap_index_01 (m_tap_index_01),
    .m_tap_index_10 (m_tap_index_10),
    .m_tap_index_11 (m_tap_index_11),
    .m_weight_00    (m_weight_00),
    .m_weight_01    (m_weight_01),
    .m_weight_10    (m_weight_10),
    .m_weight_11    (m_weight_11),
    .m_last_patch   (m_last_patch),
    .m_grid_error   (m_grid_error)
);
